// ===== sv/fpd_pkg.sv =====
// ----------------------------------------------------------------------------
// fpd_pkg: shared types and constants for the flight phase detector
// Phase codes, register indexes, widths, the default window and the MAC control struct.
// ----------------------------------------------------------------------------
package fpd_pkg;

  localparam int WindowDefault = 16;

  localparam logic [2:0] PH_PAD    = 3'd0;
  localparam logic [2:0] PH_BOOST  = 3'd1;
  localparam logic [2:0] PH_DROGUE = 3'd2;
  localparam logic [2:0] PH_MAIN   = 3'd3;
  localparam logic [2:0] PH_LANDED = 3'd4;

  localparam logic [2:0] REG_GROUND       = 3'd0;
  localparam logic [2:0] REG_LAUNCH_H     = 3'd1;
  localparam logic [2:0] REG_LAUNCH_N     = 3'd2;
  localparam logic [2:0] REG_APOGEE_N     = 3'd3;
  localparam logic [2:0] REG_MAIN_H       = 3'd4;
  localparam logic [2:0] REG_MAIN_N       = 3'd5;
  localparam logic [2:0] REG_LAND_CHG     = 3'd6;
  localparam logic [2:0] REG_LAND_N       = 3'd7;

  localparam int CfgIndexWidth = 8;
  localparam int CfgDataWidth  = 16;

  // sums: x up to 2^31, y up to 2^16, window up to 64 -> generous widths
  localparam int SxWidth  = 40;
  localparam int SyWidth  = 24;
  localparam int SxyWidth = 56;

  typedef struct packed {
    logic start;   // clear sums and begin walking the window
    logic busy;
    logic done;    // sums and numerator sign ready
  } mac_ctrl_t;

endpackage

// ===== sv/fpd_slope.sv =====
// ----------------------------------------------------------------------------
// fpd_slope: sample window and sequential least-squares slope sign
// Stores heights and ticks, walks the window with one shared multiplier, then compares two final products.
// ----------------------------------------------------------------------------
module fpd_slope #(
  parameter int WINDOW = fpd_pkg::WindowDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [31:0]             now,
  input  logic signed [16:0]      new_height,
  output fpd_pkg::mac_ctrl_t      ctrl,
  output logic                    negative
);

  localparam int PtrWidth = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CntWidth = $clog2(WINDOW + 1);
  localparam logic [CntWidth-1:0] LastIdx = CntWidth'(WINDOW - 1);

  // memory, written and read in clocked blocks; a valid bit per entry
  // stands in for the reset clear (invalid reads as zero time, zero height)
  logic signed [16:0] height_mem [WINDOW];
  logic [31:0]        time_mem   [WINDOW];
  logic [WINDOW-1:0]  valid;
  logic [PtrWidth-1:0] ring_pointer;
  logic [PtrWidth-1:0] rd_addr;
  logic [31:0]        now_q;

  logic [2:0]         step;   // 0 idle, 1 walk, 2 drain, 3 final mult, 4 compare, 5 done
  logic [CntWidth-1:0] idx;
  logic               rd_ok;
  logic signed [16:0] rd_h;
  logic [31:0]        rd_t;
  logic               ent_ok;
  logic signed [32:0] x_reg;
  logic signed [17:0] y_reg;
  logic               mul_ok;
  logic signed [49:0] prod;
  logic signed [fpd_pkg::SxWidth-1:0]  sx;
  logic signed [fpd_pkg::SyWidth-1:0]  sy;
  logic signed [fpd_pkg::SxyWidth-1:0] sxy;
  logic signed [63:0] fin_a;
  logic signed [63:0] fin_b;
  logic               fin_ok;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_FA   = 3'd2;
  localparam logic [2:0] S_FB   = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  assign rd_addr = idx[PtrWidth-1:0];

  always_ff @(posedge clk) begin
    if (start) begin
      height_mem[ring_pointer] <= new_height;
      time_mem[ring_pointer]   <= now;
      now_q                    <= now;
    end
    rd_h <= height_mem[rd_addr];
    rd_t <= time_mem[rd_addr];
  end

  // times relative to the current tick, wrapped to 32 bits
  logic signed [31:0] rel;
  logic signed [31:0] rel_zero;
  assign rel      = $signed(rd_t - now_q);
  assign rel_zero = $signed(32'd0 - now_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= '0;
      ring_pointer <= '0;
      step         <= S_IDLE;
      idx          <= '0;
      rd_ok        <= 1'b0;
      ent_ok       <= 1'b0;
      mul_ok       <= 1'b0;
      fin_ok       <= 1'b0;
      negative     <= 1'b0;
    end else begin
      rd_ok  <= (step == S_WALK);
      mul_ok <= rd_ok;
      fin_ok <= (step == S_FB);
      unique case (step)
        S_IDLE: begin
          if (start) begin
            valid[ring_pointer] <= 1'b1;
            ring_pointer <= (ring_pointer == PtrWidth'(WINDOW - 1)) ? '0 : ring_pointer + 1'b1;
            idx  <= '0;
            step <= S_WALK;
          end
        end
        S_WALK: begin
          ent_ok <= valid[rd_addr];
          if (idx == LastIdx) step <= S_FA;
          else idx <= idx + 1'b1;
        end
        S_FA: begin
          // drain the read/multiply pipe
          if (!rd_ok && !mul_ok) step <= S_FB;
        end
        S_FB: step <= S_CMP;
        S_CMP: begin
          if (fin_ok) begin
            negative <= (fin_a - fin_b) < 0;
            step     <= S_DONE;
          end
        end
        S_DONE: step <= S_IDLE;
        default: step <= S_IDLE;
      endcase
    end
  end

  // pipeline: registered operands, one shared multiplier, accumulate; final products in S_FB
  always_ff @(posedge clk) begin
    if (step == S_IDLE && start) begin
      sx <= '0;
      sy <= '0;
    end else if (mul_ok) begin
      sx <= sx + fpd_pkg::SxWidth'(x_reg);
      sy <= sy + fpd_pkg::SyWidth'(y_reg);
    end
    if (rd_ok) begin
      x_reg <= ent_ok ? 33'(rel) : 33'(rel_zero);
      y_reg <= ent_ok ? 18'(rd_h) : '0;
    end
    if (mul_ok) prod <= x_reg * y_reg;
    if (step == S_FB) begin
      fin_a <= 64'(sxy) * 64'(WINDOW);
      fin_b <= sx * sy;
    end
  end

  // products land in the cycle after mul_ok, flagged by prod_ok
  logic prod_ok;
  always_ff @(posedge clk) begin
    if (rst) prod_ok <= 1'b0;
    else prod_ok <= mul_ok;
    if (step == S_IDLE && start) sxy <= '0;
    else if (prod_ok) sxy <= sxy + fpd_pkg::SxyWidth'(prod);
  end

  assign ctrl.start = start;
  assign ctrl.busy  = (step != S_IDLE);
  assign ctrl.done  = (step == S_DONE);

  always_ff @(posedge clk) begin
    if (!rst) begin
      assert (!(step == S_DONE && prod_ok))
        else $error("slope result taken before last product was summed");
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> step == S_IDLE) else $error("slope started while busy");
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    step == S_DONE |=> step == S_IDLE) else $error("slope done lingered");
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    step == S_WALK |-> idx <= LastIdx) else $error("window index out of range");

endmodule

// ===== sv/flight_phase_detector.sv =====
// ----------------------------------------------------------------------------
// flight_phase_detector: debounced flight phase from altimeter samples
//
// Input channel (in_valid/in_stall) takes a tick and raw altitude word. The
// height above ground enters a window of recent samples and the sign of the
// least-squares slope over the window is formed by walking it with a single
// multiplier, one entry per cycle, and no new input word is taken while that
// walk is busy. The phase machine then updates and one result word goes to
// the output register.
// Output channel (out_valid/out_stall): the result waits while stalled and
// the block takes no new word until it is gone.
// Config channel (cfg_valid/cfg_ready) writes the eight thresholds; write
// only while idle. Reset restores default thresholds, pad phase, an empty
// window (valid bits cleared at once) and no pending result.
// ----------------------------------------------------------------------------
module flight_phase_detector #(
  parameter int WINDOW = fpd_pkg::WindowDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          tick,
  input  logic [15:0]          altitude,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           phase,
  output logic                 phase_changed,
  output logic signed [16:0]   height,
  output logic                 descending,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [fpd_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [fpd_pkg::CfgDataWidth-1:0]  cfg_data
);

  logic [15:0] ground_altitude, launch_height, main_height, landing_change;
  logic [7:0]  launch_count, apogee_count, main_count, landing_count;

  logic [2:0]  flight_phase;
  logic [7:0]  hit_counter;
  logic [15:0] last_altitude;
  logic        busy;
  logic signed [16:0] cur_height;
  logic [15:0] cur_alt;
  logic        in_take;
  logic        negative;
  fpd_pkg::mac_ctrl_t ctrl;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy || out_valid;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ground_altitude <= 16'd0;
      launch_height   <= 16'd100;
      launch_count    <= 8'd3;
      apogee_count    <= 8'd3;
      main_height     <= 16'd1500;
      main_count      <= 8'd3;
      landing_change  <= 16'd5;
      landing_count   <= 8'd10;
    end else if (cfg_valid && cfg_index[7:3] == 5'd0) begin
      unique case (cfg_index[2:0])
        fpd_pkg::REG_GROUND:   ground_altitude <= cfg_data;
        fpd_pkg::REG_LAUNCH_H: launch_height   <= cfg_data;
        fpd_pkg::REG_LAUNCH_N: launch_count    <= cfg_data[7:0];
        fpd_pkg::REG_APOGEE_N: apogee_count    <= cfg_data[7:0];
        fpd_pkg::REG_MAIN_H:   main_height     <= cfg_data;
        fpd_pkg::REG_MAIN_N:   main_count      <= cfg_data[7:0];
        fpd_pkg::REG_LAND_CHG: landing_change  <= cfg_data;
        fpd_pkg::REG_LAND_N:   landing_count   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic signed [16:0] take_height;
  assign take_height = $signed({1'b0, altitude}) - $signed({1'b0, ground_altitude});

  fpd_slope #(.WINDOW(WINDOW)) u_slope (
    .clk(clk), .rst(rst), .start(in_take), .now(tick), .new_height(take_height),
    .ctrl(ctrl), .negative(negative)
  );

  always_ff @(posedge clk) begin
    if (in_take) begin
      cur_height <= take_height;
      cur_alt    <= altitude;
    end
  end

  // phase update
  logic [7:0]  hc_up;
  logic [15:0] adiff;
  logic        cond;
  logic [2:0]  ph_next;
  logic [7:0]  hc_next;
  logic [15:0] la_next;
  assign hc_up = (hit_counter == 8'hFF) ? hit_counter : hit_counter + 8'd1;
  assign adiff = (cur_alt >= last_altitude) ? cur_alt - last_altitude
                                            : last_altitude - cur_alt;

  always_comb begin
    ph_next = flight_phase;
    hc_next = hit_counter;
    la_next = last_altitude;
    cond    = 1'b0;
    unique case (flight_phase)
      fpd_pkg::PH_PAD: begin
        cond = cur_height > $signed({1'b0, launch_height});
        if (cond) begin
          hc_next = hc_up;
          if (hc_up > launch_count) ph_next = fpd_pkg::PH_BOOST;
        end else hc_next = '0;
      end
      fpd_pkg::PH_BOOST: begin
        if (negative) begin
          hc_next = hc_up;
          if (hc_up > apogee_count) begin
            ph_next = fpd_pkg::PH_DROGUE;
            hc_next = '0;
          end
        end else hc_next = '0;
      end
      fpd_pkg::PH_DROGUE: begin
        cond = cur_height < $signed({1'b0, main_height});
        if (cond) begin
          hc_next = hc_up;
          if (hc_up > main_count) begin
            ph_next = fpd_pkg::PH_MAIN;
            la_next = cur_alt;
            hc_next = '0;
          end
        end else hc_next = '0;
      end
      fpd_pkg::PH_MAIN: begin
        if (adiff < landing_change) begin
          hc_next = hc_up;
          if (hc_up > landing_count) begin
            ph_next = fpd_pkg::PH_LANDED;
            hc_next = '0;
          end
        end else hc_next = '0;
        la_next = cur_alt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flight_phase  <= fpd_pkg::PH_PAD;
      hit_counter   <= '0;
      last_altitude <= '0;
      busy          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (in_take) busy <= 1'b1;
      if (ctrl.done) begin
        busy          <= 1'b0;
        out_valid     <= 1'b1;
        flight_phase  <= ph_next;
        hit_counter   <= hc_next;
        last_altitude <= la_next;
        phase         <= ph_next;
        phase_changed <= ph_next != flight_phase;
        height        <= cur_height;
        descending    <= negative;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_take |=> busy) else $error("word accepted without going busy");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    ctrl.done |-> busy && !out_valid) else $error("result without pending word");
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    flight_phase <= fpd_pkg::PH_LANDED) else $error("phase code out of range");
  a_landed_stays: assert property (@(posedge clk) disable iff (rst)
    flight_phase == fpd_pkg::PH_LANDED |=> flight_phase == fpd_pkg::PH_LANDED)
    else $error("left landed phase");

endmodule

// ===== tb/flight_phase_detector_tb.sv =====
// ----------------------------------------------------------------------------
// flight_phase_detector_tb: self-checking bench for the flight phase detector
// Feeds a directed set, random noise on the pad and one simulated flight with
// random content. A scoreboard tracks window, thresholds and phase state and
// checks every result word in order under random idle and stall patterns.
// ----------------------------------------------------------------------------
module flight_phase_detector_tb;

  localparam int RingDepth  = 16;
  localparam int CycleLimit = 1000000;

  typedef struct packed {
    logic [2:0]         phase;
    logic               changed;
    logic signed [16:0] height;
    logic               descending;
  } flight_result_t;

  class phase_scoreboard;
    logic [15:0] ground, launch_h, main_h, land_chg;
    logic [7:0]  launch_n, apogee_n, main_n, land_n;
    logic [2:0]  ph;
    logic [7:0]  hits;
    logic signed [16:0] h_ring[RingDepth];
    logic [31:0] t_ring[RingDepth];
    int          wr_ptr;
    logic [15:0] last_alt;
    flight_result_t pending[$];
    int          errors;
    int          checked;
    int          changes;

    function new();
      ground = 16'd0; launch_h = 16'd100; launch_n = 8'd3; apogee_n = 8'd3;
      main_h = 16'd1500; main_n = 8'd3; land_chg = 16'd5; land_n = 8'd10;
      ph = fpd_pkg::PH_PAD; hits = 8'd0; wr_ptr = 0; last_alt = 16'd0;
      errors = 0; checked = 0; changes = 0;
      for (int i = 0; i < RingDepth; i++) begin
        h_ring[i] = '0;
        t_ring[i] = '0;
      end
    endfunction

    function void write_reg(logic [7:0] idx, logic [15:0] d);
      case (idx)
        fpd_pkg::REG_GROUND:   ground = d;
        fpd_pkg::REG_LAUNCH_H: launch_h = d;
        fpd_pkg::REG_LAUNCH_N: launch_n = d[7:0];
        fpd_pkg::REG_APOGEE_N: apogee_n = d[7:0];
        fpd_pkg::REG_MAIN_H:   main_h = d;
        fpd_pkg::REG_MAIN_N:   main_n = d[7:0];
        fpd_pkg::REG_LAND_CHG: land_chg = d;
        fpd_pkg::REG_LAND_N:   land_n = d[7:0];
        default: ;
      endcase
    endfunction

    function void note_input(logic [31:0] tk, logic [15:0] alt);
      longint sx, sy, sxy, x, y;
      logic [31:0] d;
      logic signed [16:0] h;
      logic desc;
      logic [2:0] prev;
      logic [15:0] diff;
      flight_result_t r;
      h = $signed({1'b0, alt}) - $signed({1'b0, ground});
      h_ring[wr_ptr] = h;
      t_ring[wr_ptr] = tk;
      wr_ptr = (wr_ptr + 1) % RingDepth;
      sx = 0; sy = 0; sxy = 0;
      for (int i = 0; i < RingDepth; i++) begin
        d = t_ring[i] - tk;   // wraps mod 2^32, read signed
        x = $signed(d);
        y = h_ring[i];
        sx += x;
        sy += y;
        sxy += x * y;
      end
      desc = (longint'(RingDepth) * sxy - sx * sy) < 0;
      prev = ph;
      case (ph)
        fpd_pkg::PH_PAD: begin
          if (h > $signed({1'b0, launch_h})) begin
            if (hits != 8'hFF) hits++;
            if (hits > launch_n) ph = fpd_pkg::PH_BOOST;
          end else hits = '0;
        end
        fpd_pkg::PH_BOOST: begin
          if (desc) begin
            if (hits != 8'hFF) hits++;
            if (hits > apogee_n) begin
              ph = fpd_pkg::PH_DROGUE;
              hits = '0;
            end
          end else hits = '0;
        end
        fpd_pkg::PH_DROGUE: begin
          if (h < $signed({1'b0, main_h})) begin
            if (hits != 8'hFF) hits++;
            if (hits > main_n) begin
              ph = fpd_pkg::PH_MAIN;
              last_alt = alt;
              hits = '0;
            end
          end else hits = '0;
        end
        fpd_pkg::PH_MAIN: begin
          diff = (alt >= last_alt) ? alt - last_alt : last_alt - alt;
          if (diff < land_chg) begin
            if (hits != 8'hFF) hits++;
            if (hits > land_n) begin
              ph = fpd_pkg::PH_LANDED;
              hits = '0;
            end
          end else hits = '0;
          last_alt = alt;
        end
        default: ;
      endcase
      r.phase = ph;
      r.changed = (ph != prev);
      r.height = h;
      r.descending = desc;
      if (r.changed) changes++;
      pending.push_back(r);
    endfunction

    function void check_result(flight_result_t got);
      flight_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word phase=%0d height=%0d", $time,
                 got.phase, got.height);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.phase != want.phase) begin
        $display("%0t: phase exp %0d act %0d", $time, want.phase, got.phase);
        errors++;
      end
      if (got.changed != want.changed) begin
        $display("%0t: phase_changed exp %0d act %0d", $time, want.changed,
                 got.changed);
        errors++;
      end
      if (got.height != want.height) begin
        $display("%0t: height exp %0d act %0d", $time, want.height, got.height);
        errors++;
      end
      if (got.descending != want.descending) begin
        $display("%0t: descending exp %0d act %0d", $time, want.descending,
                 got.descending);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] tick = '0;
  logic [15:0] altitude = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] phase;
  logic phase_changed;
  logic signed [16:0] height;
  logic descending;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [fpd_pkg::CfgIndexWidth-1:0] cfg_index = '0;
  logic [fpd_pkg::CfgDataWidth-1:0] cfg_data = '0;

  phase_scoreboard sb = new();
  logic word_taken = 1'b0;
  logic cfg_taken = 1'b0;
  int   sent = 0;
  int   send_idle_pct = 27;
  int   recv_stall_pct = 79;
  int   hold_cycles = 0;
  int   cycles = 0;
  logic [31:0] now_tick = '0;

  flight_phase_detector dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .tick(tick), .altitude(altitude),
    .out_valid(out_valid), .out_stall(out_stall), .phase(phase),
    .phase_changed(phase_changed), .height(height), .descending(descending),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    word_taken <= in_valid && !in_stall;
    cfg_taken <= cfg_valid && cfg_ready;
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_input(tick, altitude);
      if (out_valid && !out_stall)
        sb.check_result('{phase, phase_changed, height, descending});
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_word(logic [31:0] tk, logic [15:0] alt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    tick = tk;
    altitude = alt;
    do @(negedge clk); while (!word_taken);
    in_valid = 1'b0;
    sent++;
    // idling pattern follows the progress of the run
    if (sent == 500) begin
      send_idle_pct = 79;
      recv_stall_pct = 27;
    end else if (sent == 1000) begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles = 400;
    end
  endtask

  task automatic next_sample(logic [15:0] alt);
    now_tick = now_tick + $urandom_range(1, 60);
    send_word(now_tick, alt);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] d);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid = 1'b0;
  endtask

  // registers are only touched with the block drained
  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  initial begin
    logic [15:0] alt;
    int n;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // keep the rocket on the pad: saturated counter never exceeds 255
    write_reg(fpd_pkg::REG_LAUNCH_N, 16'd255);
    write_reg(fpd_pkg::REG_LAUNCH_H, 16'd0);
    write_reg(8'd8, 16'hFFFF);       // outside the map, ignored
    write_reg(8'd255, 16'h1234);
    // all times equal across the whole window
    for (int i = 0; i < 17; i++) send_word(32'd0, 16'($urandom));
    send_word(32'hFFFF_FFFF, 16'hFFFF);
    send_word(32'h0000_0002, 16'h0000); // tick wraps
    send_word(32'h7FFF_FFFF, 16'hFFFF);
    send_word(32'h8000_0000, 16'h0000);
    drain();
    write_reg(fpd_pkg::REG_GROUND, 16'hFFFF);  // heights all at or below zero
    send_word(32'h8000_0010, 16'h0000);
    send_word(32'h8000_0020, 16'hFFFF);
    send_word(32'h8000_0030, 16'h7FFF);
    drain();

    // pad noise over the full field ranges and a sweep of thresholds
    for (int p = 0; p < 5; p++) begin
      write_reg(fpd_pkg::REG_GROUND, (p == 0) ? 16'd0 : 16'($urandom));
      write_reg(fpd_pkg::REG_LAUNCH_H, (p == 1) ? 16'hFFFF : 16'($urandom));
      for (int i = 0; i < 96; i++) send_word($urandom, 16'($urandom));
      drain();
    end

    // one flight: ground at 1000 ft, launch well defined
    now_tick = $urandom;
    write_reg(fpd_pkg::REG_GROUND, 16'd1000);
    write_reg(fpd_pkg::REG_LAUNCH_H, 16'd100);
    write_reg(fpd_pkg::REG_LAUNCH_N, 16'd3);
    write_reg(fpd_pkg::REG_APOGEE_N, 16'd255);
    write_reg(fpd_pkg::REG_MAIN_H, 16'd1500);
    write_reg(fpd_pkg::REG_MAIN_N, 16'd255);
    write_reg(fpd_pkg::REG_LAND_CHG, 16'hFFFF);
    write_reg(fpd_pkg::REG_LAND_N, 16'd255);
    for (int i = 0; i < 20; i++) next_sample(16'(1000 + $urandom_range(0, 150)));
    alt = 16'd1000;
    n = 0;
    while (sb.ph == fpd_pkg::PH_PAD && n < 200) begin
      alt = 16'(alt + $urandom_range(50, 400));
      next_sample(alt);
      n++;
    end
    // boost with apogee blocked: random climbs and dips
    for (int i = 0; i < 250; i++) begin
      alt = 16'(alt + $urandom_range(0, 300) - 140);
      if (alt < 16'd3000) alt = 16'd3000;
      if (alt > 16'd60000) alt = 16'd60000;
      next_sample(alt);
    end
    drain();
    write_reg(fpd_pkg::REG_APOGEE_N, 16'd0);
    drain();
    write_reg(fpd_pkg::REG_APOGEE_N, 16'd2);
    n = 0;
    while (sb.ph == fpd_pkg::PH_BOOST && n < 200) begin
      alt = (alt > 16'd300) ? 16'(alt - $urandom_range(20, 300)) : alt;
      next_sample(alt);
      n++;
    end
    // drogue: descend below main height with main blocked
    for (int i = 0; i < 200; i++) begin
      alt = (alt > 16'd1400) ? 16'(alt - $urandom_range(0, 300))
                             : 16'(1000 + $urandom_range(0, 600));
      next_sample(alt);
    end
    drain();
    write_reg(fpd_pkg::REG_MAIN_H, 16'hFFFF);
    write_reg(fpd_pkg::REG_MAIN_N, 16'd0);
    n = 0;
    while (sb.ph == fpd_pkg::PH_DROGUE && n < 50) begin
      next_sample(alt);
      n++;
    end
    // main: every sample still while landing is blocked
    for (int i = 0; i < 150; i++) next_sample(16'($urandom));
    drain();
    write_reg(fpd_pkg::REG_LAND_CHG, 16'd0);     // nothing counts as still
    for (int i = 0; i < 40; i++) next_sample(16'(1000 + $urandom_range(0, 10)));
    drain();
    write_reg(fpd_pkg::REG_LAND_CHG, 16'd5);
    write_reg(fpd_pkg::REG_LAND_N, 16'd10);
    alt = 16'd1010;
    n = 0;
    while (sb.ph == fpd_pkg::PH_MAIN && n < 200) begin
      alt = ($urandom_range(9) == 0) ? 16'(alt + 9) : 16'(alt + $urandom_range(0, 3) - 1);
      next_sample(alt);
      n++;
    end
    // landed: nothing moves any more
    for (int i = 0; i < 300; i++) send_word($urandom, 16'($urandom));

    drain();
    $display("Sent %0d samples, checked %0d results, %0d phase changes, final phase %0d",
             sent, sb.checked, sb.changes, sb.ph);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
